/* src/png_filter_reversal_macros.svh */
// Assertion macros used by the filter reversal top level.
`ifndef PNG_FILTER_REVERSAL_MACROS_SVH
`define PNG_FILTER_REVERSAL_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication, checked out of reset.
`define PNGF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset.
`define PNGF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PNGF_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define PNGF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

/* src/pngf_pkg.sv */
// Shared types and constants for the PNG filter reversal block.
`timescale 1ns / 1ps
package pngf_pkg;

    localparam int MAX_ROW_BYTES_DEF = 8192;
    localparam int QUEUE_DEPTH       = 4;

    localparam int BYTE_W     = 8;
    localparam int ROW_LEN_W  = 14;
    localparam int SAMPLE_W   = 3;
    localparam int ROWS_W     = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    typedef logic [2:0] t_filter;
    localparam t_filter FLT_NONE  = 3'd0;
    localparam t_filter FLT_SUB   = 3'd1;
    localparam t_filter FLT_UP    = 3'd2;
    localparam t_filter FLT_AVG   = 3'd3;
    localparam t_filter FLT_PAETH = 3'd4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_ROW_LENGTH   = 2'd0;
    localparam t_cfg_idx CFG_SAMPLE_BYTES = 2'd1;
    localparam t_cfg_idx CFG_IMAGE_ROWS   = 2'd2;

    localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST   = 14'd8192;
    localparam logic [SAMPLE_W-1:0]  SAMPLE_BYTES_RST = 3'd1;
    localparam logic [ROWS_W-1:0]    IMAGE_ROWS_RST   = 16'd1;

    // One classified data byte handed from the front to the back.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        t_filter           filter;
        logic              row_start;
        logic              first_row;
        logic              row_end;
        logic              image_end;
    } t_item;

endpackage

/* src/png_filter_reversal.sv */
// Top level of the PNG filter reversal block: config registers and the front/back split.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (i_valid / o_stall / i_in_byte) takes the filtered stream, one byte per
//   request: a filter type byte at each row start, then row_length data bytes.
//   Output channel (o_valid / i_stall) delivers one reconstructed byte per data byte,
//   with o_row_end on the last byte of a row and o_image_end on the last byte of an image.
//   Filter type bytes produce no output request.
//   Config channel (i_cfg_valid / o_cfg_ready) writes row_length (0), sample_bytes (1)
//   and image_rows (2); o_cfg_ready is always high. Write only while the block is idle.
// Path: an accepted data byte goes through the queue, the row store read stage and
//   the output register before it appears at the output.
// Throughput: one byte per cycle, sustained while i_stall stays low; the loop from a
//   reconstructed byte back to the left-neighbor window closes through r_left and sets that figure.
// Reset: synchronous, active low; the position, row count and windows clear, the next
//   byte is taken as a filter type and the next row is the first of an image. The row
//   store is not cleared; the first row of an image never reads it.
// Stall: when i_stall holds the output, the output register and read stage hold, the
//   4-entry queue fills, and o_stall rises once it is full.
//
module png_filter_reversal #(
    parameter int MAX_ROW_BYTES = pngf_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Input stream
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [pngf_pkg::BYTE_W-1:0]         i_in_byte,
    // Output stream
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [pngf_pkg::BYTE_W-1:0]         o_out_byte,
    output logic                                o_row_end,
    output logic                                o_image_end,
    // Config writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [pngf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pngf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

`include "png_filter_reversal_macros.svh"

    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int QW = $bits(pngf_pkg::t_item) + AW;

    logic [pngf_pkg::ROW_LEN_W-1:0] r_row_length;
    logic [pngf_pkg::SAMPLE_W-1:0]  r_sample_bytes;
    logic [pngf_pkg::ROWS_W-1:0]    r_image_rows;

    logic                 w_push;
    logic                 w_pop;
    logic                 w_full;
    logic                 w_empty;
    pngf_pkg::t_item      w_f_item;
    logic [AW-1:0]        w_f_idx;
    pngf_pkg::t_item      w_b_item;
    logic [AW-1:0]        w_b_idx;
    logic [QW-1:0]        w_q_out;

    // Config registers: always ready, unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length   <= pngf_pkg::ROW_LENGTH_RST;
            r_sample_bytes <= pngf_pkg::SAMPLE_BYTES_RST;
            r_image_rows   <= pngf_pkg::IMAGE_ROWS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                pngf_pkg::CFG_ROW_LENGTH:   r_row_length   <= i_cfg_data[pngf_pkg::ROW_LEN_W-1:0];
                pngf_pkg::CFG_SAMPLE_BYTES: r_sample_bytes <= i_cfg_data[pngf_pkg::SAMPLE_W-1:0];
                pngf_pkg::CFG_IMAGE_ROWS:   r_image_rows   <= i_cfg_data[pngf_pkg::ROWS_W-1:0];
                default: ;
            endcase
        end
    end

    // Front: position tracking and classification of each accepted byte.
    pngf_front #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_byte    (i_in_byte),
        .i_row_length (r_row_length),
        .i_image_rows (r_image_rows),
        .i_q_full     (w_full),
        .o_stall      (o_stall),
        .o_push       (w_push),
        .o_item       (w_f_item),
        .o_idx        (w_f_idx)
    );

    // Queue between the two halves so each side stalls on its own.
    pngf_queue #(
        .WIDTH (QW),
        .DEPTH (pngf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_item, w_f_idx}),
        .i_pop   (w_pop),
        .o_data  (w_q_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    assign w_b_item = pngf_pkg::t_item'(w_q_out[QW-1:AW]);
    assign w_b_idx  = w_q_out[AW-1:0];

    // Back: row store, prediction and the output register.
    pngf_back #(
        .MAX_ROW_BYTES (MAX_ROW_BYTES)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_bytes (r_sample_bytes),
        .i_q_valid      (!w_empty),
        .i_q_item       (w_b_item),
        .i_q_idx        (w_b_idx),
        .o_q_pop        (w_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_row_end      (o_row_end),
        .o_image_end    (o_image_end)
    );

    // An image always ends on a row end.
    `PNGF_ASSERT_IMPL(a_iend_on_rend, i_clk, i_rst_n,
        o_valid && o_image_end, o_row_end, "image end without row end")
    // The front never pushes into a full queue.
    `PNGF_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, w_push, !w_full, "queue overflow")
    // The back never pops an empty queue.
    `PNGF_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, w_pop, !w_empty, "queue underflow")
    // A result taken with nothing in flight leaves the output empty next cycle.
    `PNGF_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n,
        o_valid && !i_stall && w_empty && !w_pop && !u_back.r_s1_valid,
        !o_valid, "stale output")

endmodule

/* src/pngf_front.sv */
// Front end: takes stream bytes, tracks row and image position, classifies data bytes.
`timescale 1ns / 1ps
module pngf_front #(
    parameter int MAX_ROW_BYTES = pngf_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [pngf_pkg::BYTE_W-1:0]        i_in_byte,
    input  logic [pngf_pkg::ROW_LEN_W-1:0]     i_row_length,
    input  logic [pngf_pkg::ROWS_W-1:0]        i_image_rows,
    input  logic                               i_q_full,
    output logic                               o_stall,
    output logic                               o_push,
    output pngf_pkg::t_item                    o_item,
    output logic [$clog2(MAX_ROW_BYTES)-1:0]   o_idx
);

    localparam int AW = $clog2(MAX_ROW_BYTES);
    localparam int PW = $clog2(MAX_ROW_BYTES + 1);
    localparam int CW = (PW > pngf_pkg::ROW_LEN_W) ? PW : pngf_pkg::ROW_LEN_W;
    localparam int RW = pngf_pkg::ROWS_W;

    logic [PW-1:0]          r_pos, n_pos;
    logic [RW-1:0]          r_row_cnt, n_row_cnt;
    logic                   r_first, n_first;
    pngf_pkg::t_filter      r_filt, n_filt;

    logic                   w_accept;
    logic [CW-1:0]          w_len_ext;
    logic [CW-1:0]          w_len_eff;
    logic [RW-1:0]          w_rows_eff;
    logic [RW:0]            w_cnt_inc;
    logic                   w_rend;
    logic                   w_iend;

    assign o_stall  = i_q_full;
    assign w_accept = i_valid && !i_q_full;

    // Clamp the row length into 1 .. MAX_ROW_BYTES.
    assign w_len_ext = CW'(i_row_length);
    always_comb begin
        if (w_len_ext == '0) begin
            w_len_eff = CW'(1);
        end else if (w_len_ext > CW'(MAX_ROW_BYTES)) begin
            w_len_eff = CW'(MAX_ROW_BYTES);
        end else begin
            w_len_eff = w_len_ext;
        end
    end

    assign w_rows_eff = (i_image_rows == '0) ? RW'(1) : i_image_rows;
    assign w_cnt_inc  = {1'b0, r_row_cnt} + (RW+1)'(1);
    assign w_rend     = (CW'(r_pos) >= w_len_eff);
    assign w_iend     = w_rend && ((w_cnt_inc[RW-1:0] >= w_rows_eff) || w_cnt_inc[RW]);

    assign o_push           = w_accept && (r_pos != '0);
    assign o_idx            = AW'(r_pos - PW'(1));
    assign o_item.data      = i_in_byte;
    assign o_item.filter    = r_filt;
    assign o_item.row_start = (r_pos == PW'(1));
    assign o_item.first_row = r_first;
    assign o_item.row_end   = w_rend;
    assign o_item.image_end = w_iend;

    always_comb begin
        n_pos     = r_pos;
        n_row_cnt = r_row_cnt;
        n_first   = r_first;
        n_filt    = r_filt;
        if (w_accept) begin
            if (r_pos == '0) begin
                n_filt = (i_in_byte <= 8'd4) ? pngf_pkg::t_filter'(i_in_byte[2:0])
                                             : pngf_pkg::FLT_NONE;
                n_pos  = PW'(1);
            end else if (w_rend) begin
                n_pos = '0;
                if (w_iend) begin
                    n_row_cnt = '0;
                    n_first   = 1'b1;
                end else begin
                    n_row_cnt = w_cnt_inc[RW-1:0];
                    n_first   = 1'b0;
                end
            end else begin
                n_pos = r_pos + PW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_row_cnt <= '0;
            r_first   <= 1'b1;
            r_filt    <= pngf_pkg::FLT_NONE;
        end else begin
            r_pos     <= n_pos;
            r_row_cnt <= n_row_cnt;
            r_first   <= n_first;
            r_filt    <= n_filt;
        end
    end

endmodule

/* src/pngf_queue.sv */
// Small FIFO that decouples the front end from the reconstruction back end.
`timescale 1ns / 1ps
module pngf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = pngf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [AW:0]      r_cnt, n_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (i_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + (AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

/* src/pngf_back.sv */
// Back end: row store read, predictor, reconstruction and output register.
`timescale 1ns / 1ps
module pngf_back #(
    parameter int MAX_ROW_BYTES = pngf_pkg::MAX_ROW_BYTES_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [pngf_pkg::SAMPLE_W-1:0]      i_sample_bytes,
    input  logic                               i_q_valid,
    input  pngf_pkg::t_item                    i_q_item,
    input  logic [$clog2(MAX_ROW_BYTES)-1:0]   i_q_idx,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic [pngf_pkg::BYTE_W-1:0]        o_out_byte,
    output logic                               o_row_end,
    output logic                               o_image_end
);

    localparam int AW = $clog2(MAX_ROW_BYTES);

    logic [7:0]        r_mem [MAX_ROW_BYTES];
    logic              r_s1_valid;
    pngf_pkg::t_item   r_s1_item;
    logic [AW-1:0]     r_s1_idx;
    logic [7:0]        r_rdata;
    logic              r_byp;
    logic [7:0]        r_byp_data;
    logic [31:0]       r_left;
    logic [31:0]       r_upleft;
    logic              r_o_valid;
    logic [7:0]        r_o_byte;
    logic              r_o_rend;
    logic              r_o_iend;

    logic              w_adv;
    logic              w_load;
    logic [1:0]        w_sel;
    logic [31:0]       w_lw;
    logic [31:0]       w_uw;
    logic [7:0]        w_left;
    logic [7:0]        w_upleft;
    logic [7:0]        w_up;
    logic [8:0]        w_avg_sum;
    logic [7:0]        w_pa;
    logic [7:0]        w_pb;
    logic [8:0]        w_ab;
    logic [8:0]        w_c2;
    logic [8:0]        w_pc;
    logic [7:0]        w_paeth;
    logic [7:0]        w_pred;
    logic [7:0]        w_val;

    assign w_adv   = r_s1_valid && (!r_o_valid || !i_stall);
    assign w_load  = i_q_valid && (!r_s1_valid || w_adv);
    assign o_q_pop = w_load;

    // Left neighbor distance, clamped into 1..4 bytes.
    always_comb begin
        if (i_sample_bytes == '0) begin
            w_sel = 2'd0;
        end else if (i_sample_bytes > 3'd4) begin
            w_sel = 2'd3;
        end else begin
            w_sel = 2'(i_sample_bytes - 3'd1);
        end
    end

    assign w_lw = r_s1_item.row_start ? '0 : r_left;
    assign w_uw = r_s1_item.row_start ? '0 : r_upleft;

    always_comb begin
        case (w_sel)
            2'd0:    begin w_left = w_lw[7:0];   w_upleft = w_uw[7:0];   end
            2'd1:    begin w_left = w_lw[15:8];  w_upleft = w_uw[15:8];  end
            2'd2:    begin w_left = w_lw[23:16]; w_upleft = w_uw[23:16]; end
            default: begin w_left = w_lw[31:24]; w_upleft = w_uw[31:24]; end
        endcase
    end

    assign w_up = r_s1_item.first_row ? 8'd0 : (r_byp ? r_byp_data : r_rdata);

    // Paeth: pa = |b - c|, pb = |a - c|, pc = |a + b - 2c|.
    assign w_pa = (w_up >= w_upleft) ? w_up - w_upleft : w_upleft - w_up;
    assign w_pb = (w_left >= w_upleft) ? w_left - w_upleft : w_upleft - w_left;
    assign w_ab = {1'b0, w_left} + {1'b0, w_up};
    assign w_c2 = {w_upleft, 1'b0};
    assign w_pc = (w_ab >= w_c2) ? w_ab - w_c2 : w_c2 - w_ab;

    always_comb begin
        if (({1'b0, w_pa} <= w_pc) && (w_pa <= w_pb)) begin
            w_paeth = w_left;
        end else if ({1'b0, w_pb} <= w_pc) begin
            w_paeth = w_up;
        end else begin
            w_paeth = w_upleft;
        end
    end

    assign w_avg_sum = {1'b0, w_left} + {1'b0, w_up};

    always_comb begin
        case (r_s1_item.filter)
            pngf_pkg::FLT_SUB:   w_pred = w_left;
            pngf_pkg::FLT_UP:    w_pred = w_up;
            pngf_pkg::FLT_AVG:   w_pred = w_avg_sum[8:1];
            pngf_pkg::FLT_PAETH: w_pred = w_paeth;
            default:             w_pred = 8'd0;
        endcase
    end

    assign w_val = r_s1_item.data + w_pred;

    // Row store: write the finished byte, read ahead for the next one.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mem[r_s1_idx] <= w_val;
        end
        if (w_load) begin
            r_rdata <= r_mem[i_q_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_s1_item  <= i_q_item;
            r_s1_idx   <= i_q_idx;
            r_byp      <= w_adv && (r_s1_idx == i_q_idx);
            r_byp_data <= w_val;
        end
        if (w_adv) begin
            r_o_byte <= w_val;
            r_o_rend <= r_s1_item.row_end;
            r_o_iend <= r_s1_item.image_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_left     <= '0;
            r_upleft   <= '0;
        end else begin
            if (w_load) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (w_adv) begin
                r_o_valid <= 1'b1;
                r_left    <= {w_lw[23:0], w_val};
                r_upleft  <= {w_uw[23:0], w_up};
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_byte  = r_o_byte;
    assign o_row_end   = r_o_rend;
    assign o_image_end = r_o_iend;

endmodule

/* dv/tb.sv */
// Self-checking testbench for the PNG filter reversal block.
`timescale 1ns / 1ps

module tb;

    localparam int                 ROW_MAX     = pngf_pkg::MAX_ROW_BYTES_DEF;
    localparam int                 CYCLE_LIMIT = 1000000;
    localparam pngf_pkg::t_cfg_idx CFG_SPARE   = 2'd3;  // unmapped index, writes are ignored

    // One reconstructed byte as it leaves the block.
    typedef struct packed {
        logic [pngf_pkg::BYTE_W-1:0] out_byte;
        logic                        row_end;
        logic                        image_end;
    } t_pix_result;

    // Clock, reset and every block input start at a known value.
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_valid     = 1'b0;
    logic [pngf_pkg::BYTE_W-1:0]     i_in_byte   = '0;
    logic                            i_stall     = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic [pngf_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [pngf_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                        o_stall;
    logic                        o_valid;
    logic [pngf_pkg::BYTE_W-1:0] o_out_byte;
    logic                        o_row_end;
    logic                        o_image_end;
    logic                        o_cfg_ready;

    png_filter_reversal u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_row_end   (o_row_end),
        .o_image_end (o_image_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Idle rates, in percent of cycles, for the stream source and the output sink.
    int src_idle_pct   = 11;
    int sink_stall_pct = 50;

    int mismatch_count = 0;
    int bytes_accepted = 0;
    int cycle_count    = 0;

    // Reconstructed bytes still owed by the block, oldest first.
    t_pix_result expected_pixels[$];
    t_pix_result next_pixel;

    // Shadow of the register file, as last written.
    logic [pngf_pkg::ROW_LEN_W-1:0] cfg_row_length   = pngf_pkg::ROW_LENGTH_RST;
    logic [pngf_pkg::SAMPLE_W-1:0]  cfg_sample_bytes = pngf_pkg::SAMPLE_BYTES_RST;
    logic [pngf_pkg::ROWS_W-1:0]    cfg_image_rows   = pngf_pkg::IMAGE_ROWS_RST;

    // Shadow of the unfilter state.
    logic [pngf_pkg::BYTE_W-1:0] prev_row [0:ROW_MAX-1];
    int                          byte_pos    = 0;      // 0: filter type byte is next
    logic [pngf_pkg::ROWS_W-1:0] rows_done   = '0;
    pngf_pkg::t_filter           cur_filter  = pngf_pkg::FLT_NONE;
    logic [31:0]                 left_hist   = '0;     // newest reconstructed byte low
    logic [31:0]                 upleft_hist = '0;     // newest previous-row byte low
    logic                        image_top   = 1'b1;   // current row is first of an image

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    // Advance the shadow state by one accepted stream byte and queue any byte it yields.
    function automatic void unfilter_predict(input logic [pngf_pkg::BYTE_W-1:0] b);
        int          len, bpp, idx, shift, rows;
        int          a, up, c, pa, pb, pc, pred;
        logic [7:0]  val;
        t_pix_result res;
        if (byte_pos == 0) begin
            // Filter type byte: unknown types fall back to None.
            cur_filter  = (b <= pngf_pkg::FLT_PAETH) ? pngf_pkg::t_filter'(b[2:0])
                                                     : pngf_pkg::FLT_NONE;
            left_hist   = '0;
            upleft_hist = '0;
            byte_pos    = 1;
        end else begin
            len = (cfg_row_length == 0) ? 1 :
                  (cfg_row_length > ROW_MAX) ? ROW_MAX : int'(cfg_row_length);
            bpp = (cfg_sample_bytes == 0) ? 1 :
                  (cfg_sample_bytes > 4) ? 4 : int'(cfg_sample_bytes);
            idx = (byte_pos - 1 >= ROW_MAX) ? ROW_MAX - 1 : byte_pos - 1;

            // Neighbors closer than one sample to the row start fall out as zero,
            // since the windows were cleared at the filter byte.
            shift = 8 * (bpp - 1);
            a     = int'((left_hist >> shift) & 32'hFF);
            up    = image_top ? 0 : int'(prev_row[idx]);
            c     = int'((upleft_hist >> shift) & 32'hFF);

            case (cur_filter)
                pngf_pkg::FLT_SUB: pred = a;
                pngf_pkg::FLT_UP:  pred = up;
                pngf_pkg::FLT_AVG: pred = (a + up) >> 1;
                pngf_pkg::FLT_PAETH: begin
                    pa = (up > c) ? up - c : c - up;
                    pb = (a > c) ? a - c : c - a;
                    pc = (a + up > 2 * c) ? a + up - 2 * c : 2 * c - a - up;
                    if (pa <= pb && pa <= pc) pred = a;
                    else if (pb <= pc)        pred = up;
                    else                      pred = c;
                end
                default: pred = 0;
            endcase
            val = 8'(int'(b) + pred);

            prev_row[idx] = val;
            left_hist     = {left_hist[23:0], val};
            upleft_hist   = {upleft_hist[23:0], 8'(up)};

            res.out_byte  = val;
            res.row_end   = (byte_pos >= len);
            res.image_end = 1'b0;
            if (res.row_end) begin
                rows      = (cfg_image_rows == 0) ? 1 : int'(cfg_image_rows);
                byte_pos  = 0;
                rows_done = rows_done + 1'b1;
                if (rows_done >= rows || rows_done == 0) begin
                    rows_done     = '0;
                    image_top     = 1'b1;
                    res.image_end = 1'b1;
                end else begin
                    image_top = 1'b0;
                end
            end else begin
                byte_pos++;
            end
            expected_pixels.push_back(res);
        end
    endfunction

    // Drive one stream byte as a request and hold it until accepted. Call at a rising edge.
    task automatic send_byte(input logic [pngf_pkg::BYTE_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_accepted++;
        unfilter_predict(b);
    endtask

    // Drop valid, wait for every owed byte, then let the pipeline settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Write one register and mirror it into the shadow copy.
    task automatic cfg_write(input pngf_pkg::t_cfg_idx idx,
                             input logic [pngf_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            pngf_pkg::CFG_ROW_LENGTH:   cfg_row_length   = data[pngf_pkg::ROW_LEN_W-1:0];
            pngf_pkg::CFG_SAMPLE_BYTES: cfg_sample_bytes = data[pngf_pkg::SAMPLE_W-1:0];
            pngf_pkg::CFG_IMAGE_ROWS:   cfg_image_rows   = data[pngf_pkg::ROWS_W-1:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [pngf_pkg::CFG_DATA_W-1:0] len,
                              input logic [pngf_pkg::CFG_DATA_W-1:0] bpp,
                              input logic [pngf_pkg::CFG_DATA_W-1:0] rows);
        wait_idle();
        cfg_write(pngf_pkg::CFG_ROW_LENGTH, len);
        cfg_write(pngf_pkg::CFG_SAMPLE_BYTES, bpp);
        cfg_write(pngf_pkg::CFG_IMAGE_ROWS, rows);
    endtask

    // Mostly known filters, now and then an unknown type byte.
    function automatic logic [pngf_pkg::BYTE_W-1:0] pick_filter();
        if ($urandom_range(99) < 85) return 8'($urandom_range(pngf_pkg::FLT_PAETH));
        return 8'($urandom_range(255, 5));
    endfunction

    // Row content styles: uniform, rail to rail, narrow spread, flat.
    // Narrow and flat rows drive the Paeth predictor into its tie cases.
    function automatic logic [pngf_pkg::BYTE_W-1:0] pick_data(input int kind,
                                                              input logic [7:0] base);
        case (kind)
            1:       return $urandom_range(1) ? 8'hFF : 8'h00;
            2:       return 8'(base + $urandom_range(2));
            3:       return base;
            default: return 8'($urandom());
        endcase
    endfunction

    // Send a filter byte, then data until the row closes (row end may move mid-row).
    task automatic send_row(input logic [pngf_pkg::BYTE_W-1:0] filt, input int kind);
        logic [7:0] base;
        base = 8'($urandom());
        send_byte(filt);
        while (byte_pos != 0) send_byte(pick_data(kind, base));
    endtask

    function automatic int pick_kind();
        int r;
        r = $urandom_range(99);
        return (r < 50) ? 0 : (r < 67) ? 1 : (r < 84) ? 2 : 3;
    endfunction

    // Finish the current image with random rows.
    task automatic close_image();
        while (!(byte_pos == 0 && image_top)) send_row(pick_filter(), pick_kind());
    endtask

    // Out of reset: one byte per sample, one row per image, and the full-width row
    // does not close early. Halfway, raise the length above the store; the row
    // still closes at the store size.
    task automatic test_reset_defaults();
        send_byte(8'(pngf_pkg::FLT_SUB));
        repeat (ROW_MAX / 2) send_byte(8'($urandom()));
        wait_idle();
        cfg_write(pngf_pkg::CFG_ROW_LENGTH, 16'h3FFF);
        while (byte_pos != 0) send_byte(8'($urandom()));
    endtask

    // Every filter type and two unknown ones on short rail-to-rail rows.
    task automatic test_filter_types();
        logic [pngf_pkg::BYTE_W-1:0] filters [7];
        filters = '{8'(pngf_pkg::FLT_NONE), 8'(pngf_pkg::FLT_SUB), 8'(pngf_pkg::FLT_UP),
                    8'(pngf_pkg::FLT_AVG), 8'(pngf_pkg::FLT_PAETH), 8'd5, 8'hFF};
        set_config(16'd2, 16'd1, 16'd2);
        foreach (filters[k]) send_row(filters[k], 1);
        close_image();
    endtask

    // Register extremes, out-of-range values and the unmapped index.
    task automatic test_register_extremes();
        // Zero acts as one for every register.
        set_config(16'd0, 16'd0, 16'd0);
        repeat (6) send_row(pick_filter(), 0);
        // Upper data bits beyond each register drop; sample bytes above four clamp.
        set_config(16'hC005, 16'hFFFF, 16'hFFFF);
        cfg_write(CFG_SPARE, 16'hFFFF);
        repeat (4) send_row(8'(pngf_pkg::FLT_PAETH), pick_kind());
        // Shrink the image under way so the next row closes it.
        wait_idle();
        cfg_write(pngf_pkg::CFG_IMAGE_ROWS, 16'd1);
        close_image();
        set_config(16'd7, 16'hFFFB, 16'd3);
        close_image();
    endtask

    // Shrink row length while a row is open, then image rows while the image is open.
    task automatic test_midrow_change();
        set_config(16'd6, 16'd1, 16'd4);
        send_row(8'(pngf_pkg::FLT_NONE), 0);
        send_byte(8'(pngf_pkg::FLT_UP));
        repeat (3) send_byte(8'($urandom()));
        wait_idle();
        cfg_write(pngf_pkg::CFG_ROW_LENGTH, 16'd2);
        send_byte(8'($urandom()));  // data taken already reach the new length: row closes
        wait_idle();
        cfg_write(pngf_pkg::CFG_IMAGE_ROWS, 16'd1);
        send_row(8'(pngf_pkg::FLT_PAETH), 0);  // row count past the new limit: image closes
    endtask

    // Random images under random settings; settings change only at image boundaries.
    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n);
        int stop_at, r;
        logic [pngf_pkg::CFG_DATA_W-1:0] len, rows;
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        stop_at        = bytes_accepted + n;
        while (bytes_accepted < stop_at) begin
            r    = $urandom_range(99);
            len  = (r < 5) ? 16'd0 : (r < 75) ? 16'($urandom_range(12, 1))
                                              : 16'($urandom_range(80, 13));
            rows = ($urandom_range(99) < 5) ? 16'd0 : 16'($urandom_range(5, 1));
            set_config(len, 16'($urandom_range(7)), rows);
            repeat ($urandom_range(3, 1)) begin
                send_row(pick_filter(), pick_kind());
                close_image();
            end
        end
    endtask

    // Compare each delivered byte against the oldest owed one; stall the output at random.
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < sink_stall_pct);
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected output byte %02h", o_out_byte));
            end else begin
                next_pixel = expected_pixels.pop_front();
                if (o_out_byte !== next_pixel.out_byte)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              o_out_byte, next_pixel.out_byte));
                if (o_row_end !== next_pixel.row_end)
                    report_mismatch($sformatf("row_end %b, want %b",
                                              o_row_end, next_pixel.row_end));
                if (o_image_end !== next_pixel.image_end)
                    report_mismatch($sformatf("image_end %b, want %b",
                                              o_image_end, next_pixel.image_end));
            end
        end
    end

    // Hard stop if the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_filter_types();
        test_register_extremes();
        test_midrow_change();

        // Source idles lightly against a busy sink, then the reverse, then full rate.
        test_random_traffic(11, 50, 667);
        test_random_traffic(50, 11, 667);
        test_random_traffic(0, 0, 667);

        wait_idle();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
